### src/crme_pkg.sv
// ----------------------------------------------------------------------------
// crme_pkg
// Shared types and constants for the controller report to MIDI converter.
// ----------------------------------------------------------------------------
package crme_pkg;

   localparam int SLIDER_MAX  = 3;
   localparam int BUTTON_MAX  = 32;
   localparam int NUM_W       = 14;
   localparam int DEN_W       = 8;

   localparam logic [3:0] NOTE_NIBBLE = 4'h9;
   localparam logic [3:0] CC_NIBBLE   = 4'hB;
   localparam logic [6:0] VEL_ON      = 7'h7F;
   localparam logic [6:0] VEL_OFF     = 7'h00;
   localparam logic [6:0] VALUE_MID   = 7'd64;
   localparam logic [6:0] VALUE_TOP   = 7'd127;

   localparam logic [2:0] REG_MIDI_CHANNEL = 3'd0;
   localparam logic [2:0] REG_DEAD_ZONE    = 3'd1;
   localparam logic [2:0] REG_SLIDER0_CC   = 3'd2;
   localparam logic [2:0] REG_SLIDER1_CC   = 3'd3;
   localparam logic [2:0] REG_SLIDER2_CC   = 3'd4;
   localparam logic [2:0] REG_TWO_SIDED    = 3'd5;
   localparam logic [2:0] REG_WARMUP       = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SL_SETUP,
      ST_SL_DIV,
      ST_SL_DONE,
      ST_BTN,
      ST_CC
   } state_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] dividend;
      logic [DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic [NUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

### src/crme_if.sv
// ----------------------------------------------------------------------------
// crme_req_if / crme_rsp_if
// Valid/ready channels carrying controller reports and MIDI messages.
// ----------------------------------------------------------------------------
interface crme_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] button_bits;
   logic [7:0]  slider0_raw;
   logic [7:0]  slider1_raw;
   logic [7:0]  slider2_raw;
   modport source (output valid, button_bits, slider0_raw, slider1_raw, slider2_raw,
                   input ready);
   modport sink   (input valid, button_bits, slider0_raw, slider1_raw, slider2_raw,
                   output ready);
endinterface

interface crme_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] status_byte;
   logic       status_sent;
   logic [6:0] data_first;
   logic [6:0] data_second;
   logic       last_message;
   modport source (output valid, status_byte, status_sent, data_first, data_second,
                   last_message, input ready);
   modport sink   (input valid, status_byte, status_sent, data_first, data_second,
                   last_message, output ready);
endinterface

### src/control_report_to_midi_events.sv
// ----------------------------------------------------------------------------
// control_report_to_midi_events
// Turns controller reports into MIDI note and control-change messages.
// ----------------------------------------------------------------------------
// One report is taken per transaction on req while the block is idle. After
// the warm-up count the block first works through the sliders, one at a time.
// An unchanged slider only passes through setup. A changed slider whose value
// needs a division goes through setup, the shared serial divider and a result
// state. Then the block scans the 32 button bits one per cycle, holding while
// the rsp side stalls a message, and steps through the three pending control
// changes. Reports swallowed in warm-up leave the block idle.
// Every message is one rsp transaction; last_message marks the final one of
// a report. Running status compares each status byte to the previous sent one.
module control_report_to_midi_events #(
   parameter int BUTTON_COUNT = 32,
   parameter int SLIDER_COUNT = 3
) (
   input  logic        clock,
   input  logic        reset,
   crme_req_if.sink    req,
   crme_rsp_if.source  rsp,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int NS = crme_pkg::SLIDER_MAX;

   // Configuration registers.
   logic [3:0] channel_ff;
   logic [5:0] dead_zone_ff;
   logic [6:0] cc_ff [NS];
   logic [2:0] two_sided_ff;

   // Report state.
   crme_pkg::state_type state_ff, state_in;
   logic [7:0]  warmup_left_ff;
   logic [31:0] prev_buttons_ff, buttons_ff, diff_ff;
   logic [7:0]  sl_ff [NS];
   logic [7:0]  prev_sl_ff [NS];
   logic [7:0]  centre_ff [NS];
   logic [7:0]  low_ff [NS];
   logic [7:0]  high_ff [NS];
   logic [6:0]  last_val_ff [NS];
   logic [6:0]  msg_val_ff [NS];
   logic [NS-1:0] emit_ff;
   logic [1:0]  k_ff;
   logic [4:0]  bit_ff;
   logic        below_ff;
   logic [6:0]  value_ff;
   logic [7:0]  last_status_ff;

   // Output register.
   logic        rsp_valid_ff;
   logic [7:0]  rsp_status_ff;
   logic        rsp_sent_ff;
   logic [6:0]  rsp_d1_ff, rsp_d2_ff;
   logic        rsp_last_ff;

   crme_pkg::div_req_type div_req;
   crme_pkg::div_rsp_type div_rsp;

   crme_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   logic        accept, out_free;
   logic [31:0] button_mask, buttons_masked;
   logic [7:0]  raw_sl [NS];
   logic [7:0]  warm_dec;
   logic        k_active, sl_changed;
   logic [7:0]  lo_new, hi_new, hi_eff, cur_sl;
   logic signed [10:0] mirror, den;
   logic [7:0]  span;
   logic [13:0] num;
   logic        need_div;
   logic [6:0]  value_now, value_div;
   logic [31:0] btn_above;
   logic [NS-1:0] cc_above;
   logic        btn_emit, cc_emit, btn_last, cc_last;
   logic [7:0]  note_status, cc_status;

   assign accept   = req.valid && req.ready;
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == crme_pkg::ST_IDLE);

   assign button_mask    = (BUTTON_COUNT >= 32) ? 32'hFFFF_FFFF
                           : ((32'd1 << BUTTON_COUNT) - 32'd1);
   assign buttons_masked = req.button_bits & button_mask;
   assign raw_sl[0] = ~req.slider0_raw;
   assign raw_sl[1] = req.slider1_raw;
   assign raw_sl[2] = req.slider2_raw;
   assign warm_dec  = warmup_left_ff - 8'd1;

   assign note_status = {crme_pkg::NOTE_NIBBLE, channel_ff};
   assign cc_status   = {crme_pkg::CC_NIBBLE, channel_ff};

   // Slider update math for the slider being set up. Tracking of the bounds
   // happens first, the mapped value is then taken from the updated bounds.
   always_comb begin
      k_active   = (32'(k_ff) < SLIDER_COUNT);
      cur_sl     = sl_ff[k_ff];
      sl_changed = (cur_sl != prev_sl_ff[k_ff]);
      lo_new     = (cur_sl < low_ff[k_ff]) ? cur_sl : low_ff[k_ff];
      hi_new     = (high_ff[k_ff] != 8'd0 && cur_sl > high_ff[k_ff]) ? cur_sl
                   : high_ff[k_ff];
      mirror     = $signed({2'b00, centre_ff[k_ff], 1'b0}) - $signed({3'b000, lo_new});
      if (hi_new != 8'd0) begin
         hi_eff = hi_new;
      end else if (mirror < 0) begin
         hi_eff = 8'd0;
      end else if (mirror > 11'sd255) begin
         hi_eff = 8'd255;
      end else begin
         hi_eff = mirror[7:0];
      end
      if (cur_sl < centre_ff[k_ff]) begin
         den = $signed({3'b000, centre_ff[k_ff]}) - $signed({5'b00000, dead_zone_ff})
               - $signed({3'b000, lo_new});
         num = {cur_sl - lo_new, 6'd0};
      end else begin
         den = $signed({3'b000, hi_eff}) - $signed({5'b00000, dead_zone_ff})
               - $signed({3'b000, centre_ff[k_ff]});
         num = {hi_eff - cur_sl, 6'd0} - {6'd0, hi_eff - cur_sl};
      end
      span = den[7:0];
      // An empty span parks the slider at the midpoint; a position beyond a
      // mirrored upper bound pins it to the top.
      need_div  = 1'b0;
      value_now = crme_pkg::VALUE_MID;
      if (den <= 0) begin
         value_now = crme_pkg::VALUE_MID;
      end else if (cur_sl >= centre_ff[k_ff] && hi_eff < cur_sl) begin
         value_now = crme_pkg::VALUE_TOP;
      end else begin
         need_div = 1'b1;
      end
   end

   assign div_req.start    = (state_ff == crme_pkg::ST_SL_SETUP) && k_active
                             && sl_changed && need_div;
   assign div_req.dividend = num;
   assign div_req.divisor  = span;

   always_comb begin
      if (below_ff) begin
         value_div = (div_rsp.quotient > 14'd64) ? crme_pkg::VALUE_MID
                     : div_rsp.quotient[6:0];
      end else begin
         value_div = (div_rsp.quotient > 14'd63) ? crme_pkg::VALUE_MID
                     : crme_pkg::VALUE_TOP - div_rsp.quotient[6:0];
      end
   end

   // Last-message lookahead: nothing further among the buttons or sliders.
   assign btn_above = (32'hFFFF_FFFF << bit_ff) << 1;
   assign cc_above  = (3'b111 << k_ff) << 1;
   assign btn_emit  = diff_ff[bit_ff];
   assign cc_emit   = emit_ff[k_ff];
   assign btn_last  = ((diff_ff & btn_above) == 32'd0) && (emit_ff == '0);
   assign cc_last   = ((emit_ff & cc_above) == '0);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         crme_pkg::ST_IDLE: begin
            if (accept && (warmup_left_ff == 8'd0 || warm_dec == 8'd0)) begin
               state_in = crme_pkg::ST_SL_SETUP;
            end
         end
         crme_pkg::ST_SL_SETUP: begin
            if (k_active && sl_changed) begin
               state_in = need_div ? crme_pkg::ST_SL_DIV : crme_pkg::ST_SL_DONE;
            end else if (k_ff == 2'(NS - 1)) begin
               state_in = crme_pkg::ST_BTN;
            end
         end
         crme_pkg::ST_SL_DIV: begin
            if (!div_rsp.busy) begin
               state_in = crme_pkg::ST_SL_DONE;
            end
         end
         crme_pkg::ST_SL_DONE: begin
            state_in = (k_ff == 2'(NS - 1)) ? crme_pkg::ST_BTN : crme_pkg::ST_SL_SETUP;
         end
         crme_pkg::ST_BTN: begin
            if ((!btn_emit || out_free) && bit_ff == 5'(crme_pkg::BUTTON_MAX - 1)) begin
               state_in = crme_pkg::ST_CC;
            end
         end
         crme_pkg::ST_CC: begin
            if ((!cc_emit || out_free) && k_ff == 2'(NS - 1)) begin
               state_in = crme_pkg::ST_IDLE;
            end
         end
         default: state_in = crme_pkg::ST_IDLE;
      endcase
   end

   // Output-side actions.
   logic       load_out;
   logic [7:0] load_status;
   logic [6:0] load_d1, load_d2;
   logic       load_last;

   always_comb begin
      load_out    = 1'b0;
      load_status = note_status;
      load_d1     = {2'b00, bit_ff};
      load_d2     = buttons_ff[bit_ff] ? crme_pkg::VEL_ON : crme_pkg::VEL_OFF;
      load_last   = btn_last;
      case (state_ff)
         crme_pkg::ST_BTN: begin
            load_out = btn_emit && out_free;
         end
         crme_pkg::ST_CC: begin
            load_out    = cc_emit && out_free;
            load_status = cc_status;
            load_d1     = cc_ff[k_ff];
            load_d2     = msg_val_ff[k_ff];
            load_last   = cc_last;
         end
         default: load_out = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= crme_pkg::ST_IDLE;
         channel_ff      <= 4'd0;
         dead_zone_ff    <= 6'd4;
         for (int i = 0; i < NS; i++) begin
            cc_ff[i]       <= 7'(i);
            prev_sl_ff[i]  <= 8'd0;
            centre_ff[i]   <= 8'd0;
            low_ff[i]      <= 8'd0;
            high_ff[i]     <= 8'd0;
            last_val_ff[i] <= crme_pkg::VALUE_MID;
         end
         two_sided_ff    <= 3'd0;
         warmup_left_ff  <= 8'd50;
         prev_buttons_ff <= 32'd0;
         last_status_ff  <= 8'd0;
         rsp_valid_ff    <= 1'b0;
         emit_ff         <= '0;
         k_ff            <= 2'd0;
         bit_ff          <= 5'd0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff   <= 1'b1;
            last_status_ff <= load_status;
         end else if (rsp.valid && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            crme_pkg::ST_IDLE: begin
               if (accept) begin
                  k_ff    <= 2'd0;
                  bit_ff  <= 5'd0;
                  emit_ff <= '0;
                  if (warmup_left_ff != 8'd0) begin
                     warmup_left_ff <= warm_dec;
                  end
                  if (warmup_left_ff == 8'd0 || warm_dec == 8'd0) begin
                     prev_buttons_ff <= buttons_masked;
                  end
                  // The report that ends warm-up sets each slider's calibration.
                  if (warmup_left_ff != 8'd0 && warm_dec == 8'd0) begin
                     for (int i = 0; i < NS; i++) begin
                        if (i < SLIDER_COUNT) begin
                           centre_ff[i]   <= raw_sl[i];
                           low_ff[i]      <= ({1'b0, raw_sl[i]} > 9'(dead_zone_ff) + 9'd1)
                                             ? raw_sl[i] - 8'(dead_zone_ff) - 8'd1 : 8'd0;
                           high_ff[i]     <= !two_sided_ff[i] ? 8'd0
                                             : ((9'(raw_sl[i]) + 9'(dead_zone_ff) + 9'd1
                                                 > 9'd255) ? 8'd255
                                                : raw_sl[i] + 8'(dead_zone_ff) + 8'd1);
                           last_val_ff[i] <= crme_pkg::VALUE_MID;
                        end
                     end
                  end
               end
            end
            crme_pkg::ST_SL_SETUP: begin
               if (k_active && sl_changed) begin
                  prev_sl_ff[k_ff] <= cur_sl;
                  low_ff[k_ff]     <= lo_new;
                  high_ff[k_ff]    <= hi_new;
               end else begin
                  k_ff <= k_ff + 2'd1;
               end
            end
            // The slider index holds while the divider runs.
            crme_pkg::ST_SL_DIV: k_ff <= k_ff;
            crme_pkg::ST_SL_DONE: begin
               if (value_ff != last_val_ff[k_ff]) begin
                  emit_ff[k_ff]     <= 1'b1;
                  msg_val_ff[k_ff]  <= value_ff;
                  last_val_ff[k_ff] <= value_ff;
               end
               k_ff <= (k_ff == 2'(NS - 1)) ? 2'd0 : k_ff + 2'd1;
            end
            crme_pkg::ST_BTN: begin
               if (!btn_emit || out_free) begin
                  bit_ff <= bit_ff + 5'd1;
                  if (bit_ff == 5'(crme_pkg::BUTTON_MAX - 1)) begin
                     k_ff <= 2'd0;
                  end
               end
            end
            crme_pkg::ST_CC: begin
               if (!cc_emit || out_free) begin
                  k_ff <= k_ff + 2'd1;
               end
            end
            default: k_ff <= 2'd0;
         endcase
         // Configuration transactions are to be taken while idle; the block itself does not
         // enforce this. A warm-up write reloads the running count only while warm-up runs.
         if (csr_we) begin
            case (csr_index)
               crme_pkg::REG_MIDI_CHANNEL: channel_ff   <= csr_wdata[3:0];
               crme_pkg::REG_DEAD_ZONE:    dead_zone_ff <= csr_wdata[5:0];
               crme_pkg::REG_SLIDER0_CC:   cc_ff[0]     <= csr_wdata[6:0];
               crme_pkg::REG_SLIDER1_CC:   cc_ff[1]     <= csr_wdata[6:0];
               crme_pkg::REG_SLIDER2_CC:   cc_ff[2]     <= csr_wdata[6:0];
               crme_pkg::REG_TWO_SIDED:    two_sided_ff <= csr_wdata[2:0];
               crme_pkg::REG_WARMUP: begin
                  if (warmup_left_ff != 8'd0) begin
                     warmup_left_ff <= (csr_wdata == 8'd0) ? 8'd1 : csr_wdata;
                  end
               end
               default: channel_ff <= channel_ff;
            endcase
         end
      end
   end

   // Payload registers: report latch, slider value and the output message.
   always_ff @(posedge clock) begin
      if (accept) begin
         buttons_ff <= buttons_masked;
         diff_ff    <= buttons_masked ^ prev_buttons_ff;
         for (int i = 0; i < NS; i++) begin
            sl_ff[i] <= raw_sl[i];
         end
      end
      if (state_ff == crme_pkg::ST_SL_SETUP) begin
         below_ff <= (cur_sl < centre_ff[k_ff]);
         if (!need_div) begin
            value_ff <= value_now;
         end
      end
      if (state_ff == crme_pkg::ST_SL_DIV && !div_rsp.busy) begin
         value_ff <= value_div;
      end
      if (load_out) begin
         rsp_status_ff <= load_status;
         rsp_sent_ff   <= (load_status != last_status_ff);
         rsp_d1_ff     <= load_d1;
         rsp_d2_ff     <= load_d2;
         rsp_last_ff   <= load_last;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status_byte  = rsp_status_ff;
   assign rsp.status_sent  = rsp_sent_ff;
   assign rsp.data_first   = rsp_d1_ff;
   assign rsp.data_second  = rsp_d2_ff;
   assign rsp.last_message = rsp_last_ff;

   // The divider is only started while a slider is being set up.
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> state_ff == crme_pkg::ST_SL_SETUP)
      else $error("divider started outside slider setup");

   // Messages are produced only once warm-up has ended.
   a_warm_done: assert property (@(posedge clock) disable iff (reset)
      load_out |-> warmup_left_ff == 8'd0)
      else $error("message produced during warm-up");

   // A slider result is never taken while the divider is still running.
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == crme_pkg::ST_SL_DONE |-> !div_rsp.busy)
      else $error("slider result taken while divider busy");

endmodule

### src/crme_divider.sv
// ----------------------------------------------------------------------------
// crme_divider
// Restoring divider, one quotient bit per clock.
// ----------------------------------------------------------------------------
module crme_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  crme_pkg::div_req_type req,
   output crme_pkg::div_rsp_type rsp
);

   localparam int CNT_W = $clog2(crme_pkg::NUM_W + 1);

   logic [CNT_W-1:0]          count_ff, count_in;
   logic [crme_pkg::NUM_W-1:0] quo_ff, quo_in;
   logic [crme_pkg::DEN_W:0]   rem_ff, rem_in;
   logic [crme_pkg::DEN_W-1:0] den_ff, den_in;
   logic [crme_pkg::DEN_W:0]   rem_sh;

   always_comb begin
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      rem_sh   = {rem_ff[crme_pkg::DEN_W-1:0], quo_ff[crme_pkg::NUM_W-1]};
      if (req.start) begin
         count_in = CNT_W'(crme_pkg::NUM_W);
         quo_in   = req.dividend;
         rem_in   = '0;
         den_in   = req.divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[crme_pkg::NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[crme_pkg::NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.busy     = (count_ff != '0);
   assign rsp.quotient = quo_ff;

endmodule
